[rtl/text_encoding_sniffer_core_defines.svh]
// Assertion macros for the text encoding sniffer.
// Included by files that carry concurrent checks; expects i_clk and i_rst_n in scope.
`ifndef TEXT_ENCODING_SNIFFER_CORE_DEFINES_SVH
`define TEXT_ENCODING_SNIFFER_CORE_DEFINES_SVH

// same-cycle implication
`define TES_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tes_pkg.sv]
// Package for the text encoding sniffer: beat types, encoding codes and mark bytes.
// No dependencies.
package tes_pkg;

    typedef enum logic [2:0] {
        ENC_ASCII   = 3'd0,
        ENC_UTF8    = 3'd1,
        ENC_UTF16LE = 3'd2,
        ENC_UTF16BE = 3'd3,
        ENC_UTF32LE = 3'd4,
        ENC_UTF32BE = 3'd5
    } t_enc;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } t_in_beat;

    typedef struct packed {
        t_enc       encoding;
        logic [2:0] prefix_length;
    } t_out_beat;

    typedef struct packed {
        logic       hit;
        t_enc       enc;
        logic [2:0] pre;
    } t_hit;

    typedef logic [4:0][7:0] t_win;

    localparam logic [7:0] BYTE_00 = 8'h00;
    localparam logic [7:0] BYTE_FE = 8'hFE;
    localparam logic [7:0] BYTE_FF = 8'hFF;
    localparam logic [7:0] BYTE_EF = 8'hEF;
    localparam logic [7:0] BYTE_BB = 8'hBB;
    localparam logic [7:0] BYTE_BF = 8'hBF;

    localparam logic [2:0] SEEN_MAX = 3'd5;
    localparam logic [2:0] MARK_LEN = 3'd4;
    localparam logic [2:0] PRE_NONE = 3'd0;
    localparam logic [2:0] PRE_BOM2 = 3'd2;
    localparam logic [2:0] PRE_BOM3 = 3'd3;
    localparam logic [2:0] PRE_BOM4 = 3'd4;

endpackage

[rtl/text_encoding_sniffer_core.sv]
// Text encoding sniffer: byte-order mark and zero-pattern detection over a byte stream.
// Depends on tes_pkg and text_encoding_sniffer_core_defines.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_beat) carries one byte per beat with a
//   last flag marking the final byte of a buffer. Output channel (o_out_valid /
//   i_out_stall / o_out_beat) gives one beat per buffer: the encoding code and the
//   number of mark bytes to skip.
//   Throughput: one byte per cycle unless the output register is full and stalled.
//   Every byte is examined in the cycle it is taken, by shallow compares over a
//   five-byte window held in registers. The result is registered and appears in the
//   output register in the cycle after the last byte is taken.
//   Reset (synchronous, active low) clears the byte count, decision and output valid;
//   the block can take a byte as soon as reset is released.
//   A stalled output holds its beat; the input is stalled only while the output
//   register is full and stalled, otherwise bytes keep flowing.
//   After each last byte the byte count, decision and high-bit flag return to their reset values.
`include "text_encoding_sniffer_core_defines.svh"

module text_encoding_sniffer_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tes_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tes_pkg::t_out_beat o_out_beat
);
    import tes_pkg::*;

    function automatic t_hit make_hit(t_enc enc, logic [2:0] pre);
        t_hit h;
        h.hit = 1'b1;
        h.enc = enc;
        h.pre = pre;
        return h;
    endfunction

    function automatic t_hit mark_match(t_win w, logic [2:0] len);
        t_hit h;
        h = '{hit: 1'b0, enc: ENC_ASCII, pre: PRE_NONE};
        case (len)
            3'd4: begin
                if (w[1] == BYTE_FF && w[2] == BYTE_FE && w[3] == BYTE_00 && w[4] == BYTE_00)
                    h = make_hit(ENC_UTF32LE, PRE_BOM4);
                else if (w[1] == BYTE_00 && w[2] == BYTE_00 && w[3] == BYTE_FE
                         && w[4] == BYTE_FF)
                    h = make_hit(ENC_UTF32BE, PRE_BOM4);
                else if (w[1] == BYTE_FE && w[2] == BYTE_FF)
                    h = make_hit(ENC_UTF16BE, PRE_BOM2);
                else if (w[1] == BYTE_FF && w[2] == BYTE_FE)
                    h = make_hit(ENC_UTF16LE, PRE_BOM2);
                else if (w[1] == BYTE_EF && w[2] == BYTE_BB && w[3] == BYTE_BF)
                    h = make_hit(ENC_UTF8, PRE_BOM3);
            end
            3'd3: begin
                if (w[2] == BYTE_FE && w[3] == BYTE_FF)
                    h = make_hit(ENC_UTF16BE, PRE_BOM2);
                else if (w[2] == BYTE_FF && w[3] == BYTE_FE)
                    h = make_hit(ENC_UTF16LE, PRE_BOM2);
                else if (w[2] == BYTE_EF && w[3] == BYTE_BB && w[4] == BYTE_BF)
                    h = make_hit(ENC_UTF8, PRE_BOM3);
            end
            3'd2: begin
                if (w[3] == BYTE_FE && w[4] == BYTE_FF)
                    h = make_hit(ENC_UTF16BE, PRE_BOM2);
                else if (w[3] == BYTE_FF && w[4] == BYTE_FE)
                    h = make_hit(ENC_UTF16LE, PRE_BOM2);
            end
            default: begin
            end
        endcase
        return h;
    endfunction

    // nz[i] is set when window byte i is non-zero; rem bytes remain from the position
    function automatic t_hit pos_match(logic [4:0] nz, logic [2:0] rem);
        t_hit h;
        h = '{hit: 1'b0, enc: ENC_ASCII, pre: PRE_NONE};
        case (rem)
            3'd5: begin
                if (nz[0] && !nz[1] && !nz[2] && !nz[3] && nz[4])
                    h = make_hit(ENC_UTF32LE, PRE_NONE);
                else if (!nz[0] && !nz[1] && !nz[2] && nz[3] && !nz[4])
                    h = make_hit(ENC_UTF32BE, PRE_NONE);
                else if (nz[0] && !nz[1] && nz[2])
                    h = make_hit(ENC_UTF16LE, PRE_NONE);
                else if (!nz[0] && nz[1] && !nz[2])
                    h = make_hit(ENC_UTF16BE, PRE_NONE);
            end
            3'd4: begin
                if (nz[1] && !nz[2] && !nz[3] && !nz[4])
                    h = make_hit(ENC_UTF32LE, PRE_NONE);
                else if (!nz[1] && !nz[2] && !nz[3] && nz[4])
                    h = make_hit(ENC_UTF32BE, PRE_NONE);
                else if (nz[1] && !nz[2] && nz[3])
                    h = make_hit(ENC_UTF16LE, PRE_NONE);
                else if (!nz[1] && nz[2] && !nz[3])
                    h = make_hit(ENC_UTF16BE, PRE_NONE);
            end
            3'd3: begin
                if (nz[2] && !nz[3] && nz[4])
                    h = make_hit(ENC_UTF16LE, PRE_NONE);
                else if (!nz[2] && nz[3] && !nz[4])
                    h = make_hit(ENC_UTF16BE, PRE_NONE);
            end
            3'd2: begin
                if (nz[3] && !nz[4])
                    h = make_hit(ENC_UTF16LE, PRE_NONE);
                else if (!nz[3] && nz[4])
                    h = make_hit(ENC_UTF16BE, PRE_NONE);
            end
            default: begin
            end
        endcase
        return h;
    endfunction

    t_win       r_window;
    logic [2:0] r_seen;
    logic       r_decided;
    t_enc       r_dec_enc;
    logic [2:0] r_dec_pre;
    logic       r_high;
    logic       r_out_valid;
    t_out_beat  r_out_beat;

    t_win       n_window;
    logic [2:0] n_seen;
    logic       n_decided;
    t_enc       n_dec_enc;
    logic [2:0] n_dec_pre;
    logic       n_high;
    t_out_beat  n_out_beat;

    logic       in_acc;
    logic       out_free;
    logic [4:0] nz;
    t_hit       mk;
    t_hit       p5;
    t_hit       p4;
    t_hit       p3;
    t_hit       p2;
    logic       mark_en;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !out_free;
    assign in_acc     = i_in_valid && out_free;

    always_comb begin
        n_window = {i_in_beat.data_byte, r_window[4:1]};
        n_seen   = (r_seen == SEEN_MAX) ? SEEN_MAX : r_seen + 3'd1;
        n_high   = r_high || i_in_beat.data_byte[7];
        for (int i = 0; i < 5; i++) begin
            nz[i] = |n_window[i];
        end
        mk = mark_match(n_window, n_seen);
        p5 = pos_match(nz, 3'd5);
        p4 = pos_match(nz, 3'd4);
        p3 = pos_match(nz, 3'd3);
        p2 = pos_match(nz, 3'd2);
        mark_en = (n_seen == MARK_LEN) || (i_in_beat.last && n_seen < MARK_LEN);

        n_decided = r_decided;
        n_dec_enc = r_dec_enc;
        n_dec_pre = r_dec_pre;
        if (!n_decided && mark_en && mk.hit) begin
            n_decided = 1'b1;
            n_dec_enc = mk.enc;
            n_dec_pre = mk.pre;
        end
        if (!n_decided && n_seen == SEEN_MAX && p5.hit) begin
            n_decided = 1'b1;
            n_dec_enc = p5.enc;
            n_dec_pre = p5.pre;
        end
        if (!n_decided && i_in_beat.last && n_seen >= 3'd4 && p4.hit) begin
            n_decided = 1'b1;
            n_dec_enc = p4.enc;
            n_dec_pre = p4.pre;
        end
        if (!n_decided && i_in_beat.last && n_seen >= 3'd3 && p3.hit) begin
            n_decided = 1'b1;
            n_dec_enc = p3.enc;
            n_dec_pre = p3.pre;
        end
        if (!n_decided && i_in_beat.last && n_seen >= 3'd2 && p2.hit) begin
            n_decided = 1'b1;
            n_dec_enc = p2.enc;
            n_dec_pre = p2.pre;
        end

        if (n_decided) begin
            n_out_beat.encoding      = n_dec_enc;
            n_out_beat.prefix_length = n_dec_pre;
        end else begin
            n_out_beat.encoding      = n_high ? ENC_UTF8 : ENC_ASCII;
            n_out_beat.prefix_length = PRE_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= '0;
            r_decided   <= 1'b0;
            r_dec_enc   <= ENC_ASCII;
            r_dec_pre   <= PRE_NONE;
            r_high      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                if (i_in_beat.last) begin
                    r_seen    <= '0;
                    r_decided <= 1'b0;
                    r_dec_enc <= ENC_ASCII;
                    r_dec_pre <= PRE_NONE;
                    r_high    <= 1'b0;
                end else begin
                    r_seen    <= n_seen;
                    r_decided <= n_decided;
                    r_dec_enc <= n_dec_enc;
                    r_dec_pre <= n_dec_pre;
                    r_high    <= n_high;
                end
            end
            if (out_free) begin
                r_out_valid <= in_acc && i_in_beat.last;
            end
        end
    end

    // window bytes beyond the count are never examined, so no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_window <= n_window;
        end
        if (out_free) begin
            r_out_beat <= n_out_beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    `TES_ASSERT_NEXT(a_last_gives_beat, in_acc && i_in_beat.last,
                     r_out_valid && r_seen == 3'd0 && !r_decided,
                     "last beat did not yield a result and clear state")
    `TES_ASSERT_NOW(a_seen_range, 1'b1, r_seen <= SEEN_MAX,
                    "byte count beyond saturation")
    `TES_ASSERT_NOW(a_decided_not_ascii, r_decided, r_dec_enc != ENC_ASCII,
                    "decision recorded as ascii")
    `TES_ASSERT_NOW(a_prefix_matches_enc,
                    r_out_valid && r_out_beat.prefix_length == PRE_BOM4,
                    r_out_beat.encoding == ENC_UTF32LE || r_out_beat.encoding == ENC_UTF32BE,
                    "four-byte mark on a non-utf32 result")

endmodule

[dv/text_encoding_sniffer_checker.sv]
`timescale 1ns / 1ps
// Checker for text_encoding_sniffer_core: tracks the byte window, mark and zero-pattern search
// per buffer, queues one expected verdict per last byte and compares each output beat.
// Depends on tes_pkg.
module text_encoding_sniffer_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  tes_pkg::t_in_beat  i_in_beat,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  tes_pkg::t_out_beat i_out_beat,
    output int                 o_fail_count,
    output int                 o_outstanding
);
    import tes_pkg::*;

    logic [7:0] win [0:4];
    logic [2:0] seen;
    t_hit       found;
    logic       high_seen;
    t_out_beat  verdicts [$];
    t_out_beat  want;
    int         fails = 0;

    function automatic void clear_state();
        for (int i = 0; i < 5; i++) win[i] = BYTE_00;
        seen      = 3'd0;
        found     = '0;
        high_seen = 1'b0;
    endfunction

    // rem bytes from this position to the buffer end, 5 meaning five or more
    function automatic t_hit scan_position(int rem);
        logic [4:0] nz;
        t_hit       h;
        nz = '0;
        h  = '0;
        for (int i = 0; i < rem; i++) nz[i] = |win[5 - rem + i];
        if (rem >= 5) begin
            if (nz[0] && !nz[1] && !nz[2] && !nz[3] && nz[4])
                h = {1'b1, ENC_UTF32LE, PRE_NONE};
            else if (!nz[0] && !nz[1] && !nz[2] && nz[3] && !nz[4])
                h = {1'b1, ENC_UTF32BE, PRE_NONE};
        end else if (rem == 4) begin
            if (nz[0] && !nz[1] && !nz[2] && !nz[3])
                h = {1'b1, ENC_UTF32LE, PRE_NONE};
            else if (!nz[0] && !nz[1] && !nz[2] && nz[3])
                h = {1'b1, ENC_UTF32BE, PRE_NONE};
        end
        if (!h.hit) begin
            if (rem >= 3) begin
                if (nz[0] && !nz[1] && nz[2])
                    h = {1'b1, ENC_UTF16LE, PRE_NONE};
                else if (!nz[0] && nz[1] && !nz[2])
                    h = {1'b1, ENC_UTF16BE, PRE_NONE};
            end else if (rem == 2) begin
                if (nz[0] && !nz[1])
                    h = {1'b1, ENC_UTF16LE, PRE_NONE};
                else if (!nz[0] && nz[1])
                    h = {1'b1, ENC_UTF16BE, PRE_NONE};
            end
        end
        return h;
    endfunction

    task automatic sniff_byte(input logic [7:0] octet, input logic is_last);
        logic [7:0] mk [0:3];
        t_out_beat  v;
        int         n;
        int         r;
        for (int i = 0; i < 4; i++) win[i] = win[i + 1];
        win[4] = octet;
        if (seen < SEEN_MAX) seen = seen + 3'd1;
        if (octet > 8'd127) high_seen = 1'b1;
        n = int'(seen);

        // four-byte marks ahead of the two- and three-byte ones
        if (!found.hit && (n == MARK_LEN || (is_last && n < MARK_LEN))) begin
            for (int i = 0; i < 4; i++) mk[i] = (i < n) ? win[5 - n + i] : BYTE_00;
            if (n >= 4 && mk[0] == BYTE_FF && mk[1] == BYTE_FE && mk[2] == BYTE_00
                    && mk[3] == BYTE_00)
                found = {1'b1, ENC_UTF32LE, PRE_BOM4};
            else if (n >= 4 && mk[0] == BYTE_00 && mk[1] == BYTE_00 && mk[2] == BYTE_FE
                    && mk[3] == BYTE_FF)
                found = {1'b1, ENC_UTF32BE, PRE_BOM4};
            else if (n >= 2 && mk[0] == BYTE_FE && mk[1] == BYTE_FF)
                found = {1'b1, ENC_UTF16BE, PRE_BOM2};
            else if (n >= 2 && mk[0] == BYTE_FF && mk[1] == BYTE_FE)
                found = {1'b1, ENC_UTF16LE, PRE_BOM2};
            else if (n >= 3 && mk[0] == BYTE_EF && mk[1] == BYTE_BB && mk[2] == BYTE_BF)
                found = {1'b1, ENC_UTF8, PRE_BOM3};
        end
        if (!found.hit && n == 5) found = scan_position(5);
        if (!found.hit && is_last) begin
            r = (n < 4) ? n : 4;
            while (!found.hit && r >= 2) begin
                found = scan_position(r);
                r--;
            end
        end

        if (is_last) begin
            if (found.hit) begin
                v.encoding      = found.enc;
                v.prefix_length = found.pre;
            end else begin
                v.encoding      = high_seen ? ENC_UTF8 : ENC_ASCII;
                v.prefix_length = PRE_NONE;
            end
            verdicts.push_back(v);
            clear_state();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
            verdicts.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (verdicts.size() == 0) begin
                    $error("unexpected result beat: encoding %0d prefix_length %0d",
                           i_out_beat.encoding, i_out_beat.prefix_length);
                    fails++;
                end else begin
                    want = verdicts.pop_front();
                    if (i_out_beat.encoding !== want.encoding) begin
                        $error("encoding: expected %0d, got %0d",
                               want.encoding, i_out_beat.encoding);
                        fails++;
                    end
                    if (i_out_beat.prefix_length !== want.prefix_length) begin
                        $error("prefix_length: expected %0d, got %0d",
                               want.prefix_length, i_out_beat.prefix_length);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                sniff_byte(i_in_beat.data_byte, i_in_beat.last);
        end
        o_fail_count  <= fails;
        o_outstanding <= verdicts.size();
    end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// Top-level bench for text_encoding_sniffer_core: sends directed and random byte buffers
// with random gaps and output stalls, and gives the verdict. Needs tes_pkg and the checker.
module tb;
    import tes_pkg::*;

    localparam int BYTE_TARGET  = 1250;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    t_in_beat   in_beat   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_beat  out_beat;
    int         fail_count;
    int         outstanding;

    int         cycles        = 0;
    int         bytes_sent    = 0;
    int         buffers_sent  = 0;
    int         stall_left    = 0;
    int         stall_pick;
    logic       burst         = 1'b0;
    logic [7:0] octets [$];

    text_encoding_sniffer_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat)
    );

    text_encoding_sniffer_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_beat     (in_beat),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_beat    (out_beat),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] text_char();
        if ($urandom_range(0, 7) == 0) return 8'($urandom_range(128, 255));
        return 8'($urandom_range(32, 126));
    endfunction

    // sink back-pressure, with the odd long free stretch
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (out_stall) begin
            out_stall  <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(30, 100)
                                                      : $urandom_range(0, 6);
        end else begin
            stall_pick = pick_gap();
            if (stall_pick > 0) begin
                out_stall  <= 1'b1;
                stall_left <= stall_pick - 1;
            end
        end
    end

    task automatic send_buffer();
        t_in_beat beat;
        int       gap;
        for (int i = 0; i < octets.size(); i++) begin
            gap = burst ? 0 : pick_gap();
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            beat.data_byte = octets[i];
            beat.last      = (i == octets.size() - 1);
            in_valid <= 1'b1;
            in_beat  <= beat;
            @(posedge clk);
            while (in_stall) @(posedge clk);
        end
        bytes_sent   += octets.size();
        buffers_sent++;
    endtask

    initial begin
        int len;
        int shape;
        int directed_buffers;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        octets = '{BYTE_FF, BYTE_FE, BYTE_00, BYTE_00};         send_buffer();
        octets = '{BYTE_00, BYTE_00, BYTE_FE, BYTE_FF};         send_buffer();
        octets = '{BYTE_FE, BYTE_FF};                           send_buffer();
        octets = '{BYTE_FF, BYTE_FE};                           send_buffer();
        octets = '{BYTE_EF, BYTE_BB, BYTE_BF};                  send_buffer();
        octets = '{BYTE_FF};                                    send_buffer();
        octets = '{BYTE_00};                                    send_buffer();
        octets = '{8'h7F, 8'h41};                               send_buffer();
        octets = '{8'h41, BYTE_00, BYTE_00, BYTE_00, 8'h42};    send_buffer();
        octets = '{BYTE_00, BYTE_00, BYTE_00, 8'h41, BYTE_00};  send_buffer();
        octets = '{BYTE_00, 8'h41, BYTE_00};                    send_buffer();
        directed_buffers = buffers_sent;

        while (bytes_sent < BYTE_TARGET) begin
            octets.delete();
            burst = ($urandom_range(0, 4) == 0);
            shape = $urandom_range(0, 9);
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(1, 12);
            case (shape)
                0, 1: begin
                    case ($urandom_range(0, 4))
                        0: octets = '{BYTE_FF, BYTE_FE, BYTE_00, BYTE_00};
                        1: octets = '{BYTE_00, BYTE_00, BYTE_FE, BYTE_FF};
                        2: octets = '{BYTE_FE, BYTE_FF};
                        3: octets = '{BYTE_FF, BYTE_FE};
                        default: octets = '{BYTE_EF, BYTE_BB, BYTE_BF};
                    endcase
                    while (octets.size() < len) octets.push_back(text_char());
                end
                2: while (octets.size() < len) begin
                    octets.push_back(text_char());
                    octets.push_back(BYTE_00);
                end
                3: while (octets.size() < len) begin
                    octets.push_back(BYTE_00);
                    octets.push_back(text_char());
                end
                4: while (octets.size() < len) begin
                    octets.push_back(text_char());
                    repeat (3) octets.push_back(BYTE_00);
                end
                5: while (octets.size() < len) begin
                    repeat (3) octets.push_back(BYTE_00);
                    octets.push_back(text_char());
                end
                6: while (octets.size() < len)
                    octets.push_back(($urandom_range(0, 15) == 0) ? BYTE_00
                                                                : 8'($urandom_range(1, 127)));
                7: while (octets.size() < len) octets.push_back(8'($urandom_range(1, 255)));
                default: while (octets.size() < len)
                    octets.push_back(($urandom_range(0, 2) == 0) ? BYTE_00
                                                               : 8'($urandom_range(0, 255)));
            endcase
            while (octets.size() > len) octets.pop_back();
            // broken sequences
            if ($urandom_range(0, 4) == 0)
                octets[$urandom_range(0, octets.size() - 1)] = 8'($urandom_range(0, 255));
            send_buffer();
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d bytes in %0d buffers (%0d directed): marks, zero patterns,",
                 bytes_sent, buffers_sent, directed_buffers);
        $display("short tails and long buffers, under random input gaps and output stalls.");
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/tes_pkg.sv
rtl/text_encoding_sniffer_core.sv
dv/text_encoding_sniffer_checker.sv
dv/tb.sv
